/* rtl/sida_pkg.sv */
// ----------------------------------------------------------------------------
// sida_pkg
// Types, constants and helpers for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdW       = 4 * NumDigits;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned BitCntW    = $clog2(ValueW);
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;
  localparam logic [7:0] AsciiNine  = 8'h39;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StFind,
    StSign,
    StDigit
  } state_e;

  // add 3 to every BCD digit of 5 or more, ahead of the shift
  function automatic logic [BcdW-1:0] dd_adjust(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    logic [3:0]      d;
    r = '0;
    for (int i = 0; i < NumDigits; i++) begin
      d = b[4*i +: 4];
      r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return r;
  endfunction

  // index of the most significant non-zero digit, 0 when all are zero
  function automatic logic [DigitIdxW-1:0] msd_index(input logic [BcdW-1:0] b);
    logic [DigitIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (b[4*i +: 4] != 4'd0) begin
        idx = DigitIdxW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [3:0] digit_at(input logic [BcdW-1:0] b,
                                          input logic [DigitIdxW-1:0] idx);
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (idx == DigitIdxW'(i)) begin
        d = b[4*i +: 4];
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// The back end pops a value, runs the 32-step double-dabble loop, finds the
// leading digit, then sends the characters (1..11 per value) on consecutive
// cycles. A two-entry queue lets start be taken while a value is converting.
// Reset clears the queue and the sequencer; no strobe is raised during reset.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic signed [sida_pkg::ValueW-1:0] value_i,
  output      logic                               strobe_o,
  output      logic [7:0]                         character_o,
  output      logic                               last_char_o
);

  sida_pkg::entry_t push_entry, pop_entry;
  logic             push, pop, full, empty;

  sida_front u_front (
    .start   (start),
    .busy    (busy),
    .value_i (value_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  sida_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  sida_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

/* rtl/sida_front.sv */
// ----------------------------------------------------------------------------
// sida_front
// Accepts a value, splits it into sign and unsigned magnitude, queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_front (
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic signed [sida_pkg::ValueW-1:0] value_i,
  input  wire logic                              full_i,
  output      logic                              push_o,
  output      sida_pkg::entry_t                  entry_o
);

  logic [sida_pkg::ValueW-1:0] raw;

  assign raw          = value_i;
  assign busy         = full_i;
  assign push_o       = start && !full_i;
  assign entry_o.neg  = raw[sida_pkg::ValueW-1];
  // unsigned negate, so the most negative value gives 2^31
  assign entry_o.mag  = entry_o.neg ? (sida_pkg::ValueW'(0) - raw) : raw;

endmodule

`default_nettype wire

/* rtl/sida_fifo.sv */
// ----------------------------------------------------------------------------
// sida_fifo
// Short queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sida_pkg::entry_t wdata_i,
  input  wire logic             pop_i,
  output      sida_pkg::entry_t rdata_o,
  output      logic             full_o,
  output      logic             empty_o
);

  localparam int unsigned PtrW = (sida_pkg::QueueDepth > 1) ? $clog2(sida_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(sida_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(sida_pkg::QueueDepth - 1);

  sida_pkg::entry_t mem_q [sida_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(sida_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/sida_back.sv */
// ----------------------------------------------------------------------------
// sida_back
// Double-dabble conversion, one bit a cycle, then character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire sida_pkg::entry_t entry_i,
  output      logic             pop_o,
  output      logic             strobe_o,
  output      logic [7:0]       character_o,
  output      logic             last_char_o
);

  sida_pkg::state_e                   state_q, state_d;
  logic [sida_pkg::ValueW-1:0]        mag_q, mag_d;
  logic [sida_pkg::BcdW-1:0]          bcd_q, bcd_d, bcd_adj;
  logic                               neg_q, neg_d;
  logic [sida_pkg::BitCntW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [sida_pkg::DigitIdxW-1:0]     dig_q, dig_d;
  logic                               strobe_q, strobe_d;
  logic [7:0]                         char_q, char_d;
  logic                               last_q, last_d;

  assign bcd_adj = sida_pkg::dd_adjust(bcd_q);

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    bit_cnt_d = bit_cnt_q;
    dig_d     = dig_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    unique case (state_q)
      sida_pkg::StIdle: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          mag_d     = entry_i.mag;
          neg_d     = entry_i.neg;
          bcd_d     = '0;
          bit_cnt_d = '1;
          state_d   = sida_pkg::StConv;
        end
      end
      sida_pkg::StConv: begin
        bcd_d     = {bcd_adj[sida_pkg::BcdW-2:0], mag_q[sida_pkg::ValueW-1]};
        mag_d     = {mag_q[sida_pkg::ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = sida_pkg::StFind;
        end
      end
      sida_pkg::StFind: begin
        dig_d   = sida_pkg::msd_index(bcd_q);
        state_d = neg_q ? sida_pkg::StSign : sida_pkg::StDigit;
      end
      sida_pkg::StSign: begin
        strobe_d = 1'b1;
        char_d   = sida_pkg::AsciiMinus;
        last_d   = 1'b0;
        state_d  = sida_pkg::StDigit;
      end
      sida_pkg::StDigit: begin
        strobe_d = 1'b1;
        char_d   = sida_pkg::AsciiZero + {4'd0, sida_pkg::digit_at(bcd_q, dig_q)};
        last_d   = (dig_q == '0);
        dig_d    = dig_q - 1'b1;
        if (dig_q == '0) begin
          state_d = sida_pkg::StIdle;
        end
      end
      default: begin
        state_d = sida_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sida_pkg::StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    neg_q     <= neg_d;
    bit_cnt_q <= bit_cnt_d;
    dig_q     <= dig_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

/* rtl/sida_chk.sv */
// ----------------------------------------------------------------------------
// sida_chk
// Port-level checks on the character beats of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module sida_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       strobe_o,
  input wire logic [7:0] character_o,
  input wire logic       last_char_o
);

  // only digits or the minus sign are ever sent
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (character_o == sida_pkg::AsciiMinus) ||
                 ((character_o >= sida_pkg::AsciiZero) &&
                  (character_o <= sida_pkg::AsciiNine)))
    else $error("illegal character");

  // a sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (character_o == sida_pkg::AsciiMinus)) |-> !last_char_o)
    else $error("minus sign flagged last");

  // beats of one number are back to back
  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_char_o) |=> strobe_o)
    else $error("gap inside a number");

  // the next number needs a full conversion first
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_char_o) |=> !strobe_o)
    else $error("beat straight after last character");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !strobe_o)
    else $error("strobe during reset");

endmodule

bind signed_int_to_decimal_ascii sida_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .strobe_o    (strobe_o),
  .character_o (character_o),
  .last_char_o (last_char_o)
);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// Values go in on the start/busy handshake. Each one is expanded into its
// expected characters when it is taken. Every strobed character is compared
// in order with that list.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 80;
  localparam int unsigned DigitBase   = 10;
  localparam int          RandomItems = 480;

  typedef struct {
    logic [7:0] character;
    logic       last_char;
  } char_beat_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic signed [sida_pkg::ValueW-1:0] value_i;
  logic                               strobe_o;
  logic [7:0]                         character_o;
  logic                               last_char_o;

  char_beat_t expected_chars[$];
  int         error_count = 0;
  int         cycle_count = 0;

  signed_int_to_decimal_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Decimal text of one value, sign first, no leading zeros.
  function automatic void predict_text(input logic [sida_pkg::ValueW-1:0] raw);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs[sida_pkg::NumDigits];
    int          nd;
    int          total;
    int          k;
    char_beat_t  beat;
    neg = raw[sida_pkg::ValueW-1];
    // magnitude as unsigned, so the most negative value does not overflow
    mag = neg ? (~raw + 32'd1) : raw;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % DigitBase);
      mag      = mag / DigitBase;
      nd++;
    end while (mag != 0 && nd < sida_pkg::NumDigits);
    total = nd + (neg ? 1 : 0);
    k = 0;
    if (neg) begin
      beat.character = sida_pkg::AsciiMinus;
      beat.last_char = (k == total - 1);
      expected_chars.push_back(beat);
      k++;
    end
    for (int d = nd - 1; d >= 0; d--) begin
      beat.character = sida_pkg::AsciiZero + 8'(digs[d]);
      beat.last_char = (k == total - 1);
      expected_chars.push_back(beat);
      k++;
    end
  endfunction

  // Result checker: one beat per strobe, oldest expectation first.
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && strobe_o) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                 $time, character_o, last_char_o);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.character) begin
          $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want.character, character_o);
          error_count++;
        end
        if (last_char_o !== want.last_char) begin
          $display("%0t: last_char mismatch: expected %0b, actual %0b",
                   $time, want.last_char, last_char_o);
          error_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken, with start still high so a following beat can go straight out.
  task automatic send_value(input logic [sida_pkg::ValueW-1:0] v);
    logic taken;
    value_i = v;
    start   = 1'b1;
    taken   = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
        predict_text(v);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int n);
    start   = 1'b0;
    value_i = $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // Zero, single digits, signs and both ends of the range.
  task automatic test_extremes();
    logic [sida_pkg::ValueW-1:0] vals[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd5,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    foreach (vals[i]) send_value(vals[i]);
    idle_for(3);
    wait_drained();
  endtask

  // Every text length, either side of each power of ten.
  task automatic test_lengths();
    longint p;
    p = 10;
    for (int k = 1; k < sida_pkg::NumDigits; k++) begin
      send_value(32'(p - 1));
      send_value(-32'(p));
      if (k % 2 == 0) idle_for($urandom_range(1, 40));
      p = p * DigitBase;
    end
    send_value(32'd1_000_000_000);
    send_value(-32'sd999_999_999);
    idle_for(2);
    wait_drained();
  endtask

  function automatic logic [sida_pkg::ValueW-1:0] random_value();
    longint mag;
    longint p;
    int     k;
    logic   neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: mag = $urandom_range(0, 20);
      2: begin
        // random digit count as a bound, random value below that power of ten
        k = $urandom_range(1, sida_pkg::NumDigits);
        p = 1;
        repeat (k) p = p * DigitBase;
        mag = (longint'($urandom) * 64'd4294967296 + $urandom) % p;
        if (mag > 64'h8000_0000) mag = mag % 64'h8000_0000;
      end
      default: begin
        k = $urandom_range(1, sida_pkg::NumDigits - 1);
        p = 1;
        repeat (k) p = p * DigitBase;
        mag = p + $urandom_range(0, 2) - 1;
      end
    endcase
    if (!neg && mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // Random values in bursts of random length, random gaps between them.
  task automatic test_random();
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        case ($urandom_range(0, 3))
          0:       ;
          1:       idle_for($urandom_range(1, 4));
          2:       idle_for($urandom_range(5, 50));
          default: idle_for($urandom_range(1, 15));
        endcase
      end
      send_value(random_value());
      burst_left--;
    end
    idle_for(1);
    wait_drained();
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_lengths();
    test_random();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sida_pkg.sv
rtl/sida_front.sv
rtl/sida_fifo.sv
rtl/sida_back.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sida_chk.sv
tb/sv/tb.sv
